FILE: hw/rtl/rmc_pkg.sv
// Shared types and constants for the RMC sentence field extractor.
// No dependencies; every other file of the block imports this package.
package rmc_pkg;

  // Longest field that is captured; longer fields are truncated.
  localparam int FIELD_CHARS = 15;

  // Entries of the queue between the parser and the output stage (power of two).
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Characters of interest.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  // Field identifiers.
  localparam logic [1:0] FID_TIME   = 2'd0;
  localparam logic [1:0] FID_STATUS = 2'd1;
  localparam logic [1:0] FID_LAT    = 2'd2;

  // One result item.
  typedef struct packed {
    logic [1:0] field_id;
    logic [3:0] char_pos;
    logic [7:0] field_char;
    logic       field_end;
  } rmc_res_t;

endpackage

FILE: hw/rtl/rmc_front.sv
// Parser front end: header match and field capture, one byte per transfer.
// Depends on rmc_pkg; feeds rmc_queue.
module rmc_front
  import rmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  output logic       push,
  output rmc_res_t   res
);

  typedef enum logic [10:0] {
    ST_HUNT = 11'b000_0000_0001,
    ST_H1   = 11'b000_0000_0010,
    ST_H2   = 11'b000_0000_0100,
    ST_H3   = 11'b000_0000_1000,
    ST_H4   = 11'b000_0001_0000,
    ST_H5   = 11'b000_0010_0000,
    ST_SKIP = 11'b000_0100_0000,
    ST_TIME = 11'b000_1000_0000,
    ST_STAT = 11'b001_0000_0000,
    ST_STSK = 11'b010_0000_0000,
    ST_LAT  = 11'b100_0000_0000
  } rmc_state_t;

  rmc_state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       emit;
  logic       is_comma;
  logic       is_dollar;
  logic       room;
  logic [7:0] hdr_char;
  rmc_state_t hdr_next;

  assign is_comma  = (in_byte == CH_COMMA);
  assign is_dollar = (in_byte == CH_DOLLAR);
  assign room      = (cnt_r < 4'(FIELD_CHARS));

  always_comb begin
    hdr_char = CH_DOLLAR;
    hdr_next = ST_H1;
    case (state_r)
      ST_HUNT: begin
        hdr_char = CH_DOLLAR;
        hdr_next = ST_H1;
      end
      ST_H1: begin
        hdr_char = CH_G;
        hdr_next = ST_H2;
      end
      ST_H2: begin
        hdr_char = CH_P;
        hdr_next = ST_H3;
      end
      ST_H3: begin
        hdr_char = CH_R;
        hdr_next = ST_H4;
      end
      ST_H4: begin
        hdr_char = CH_M;
        hdr_next = ST_H5;
      end
      ST_H5: begin
        hdr_char = CH_C;
        hdr_next = ST_SKIP;
      end
      default: begin
        hdr_char = CH_DOLLAR;
        hdr_next = ST_H1;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    emit      = 1'b0;
    res       = '0;
    case (state_r)
      ST_HUNT, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5: begin
        if (in_byte == hdr_char) begin
          state_nxt = hdr_next;
          cnt_nxt   = 4'd0;
        end else if (is_dollar) begin
          state_nxt = ST_H1;
        end else begin
          state_nxt = ST_HUNT;
        end
      end
      ST_SKIP: begin
        if (is_comma) begin
          state_nxt = ST_TIME;
          cnt_nxt   = 4'd0;
        end
      end
      ST_TIME, ST_LAT: begin
        res.field_id = (state_r == ST_TIME) ? FID_TIME : FID_LAT;
        res.char_pos = cnt_r;
        if (is_comma) begin
          emit          = 1'b1;
          res.field_end = 1'b1;
          cnt_nxt       = 4'd0;
          state_nxt     = (state_r == ST_TIME) ? ST_STAT : ST_HUNT;
        end else if (room) begin
          emit           = 1'b1;
          res.field_char = in_byte;
          cnt_nxt        = cnt_r + 4'd1;
        end
      end
      ST_STAT: begin
        emit         = 1'b1;
        res.field_id = FID_STATUS;
        if (is_comma) begin
          res.field_end = 1'b1;
          cnt_nxt       = 4'd0;
          state_nxt     = ST_LAT;
        end else begin
          res.field_char = in_byte;
          cnt_nxt        = 4'd1;
          state_nxt      = ST_STSK;
        end
      end
      ST_STSK: begin
        if (is_comma) begin
          emit          = 1'b1;
          res.field_id  = FID_STATUS;
          res.char_pos  = cnt_r;
          res.field_end = 1'b1;
          cnt_nxt       = 4'd0;
          state_nxt     = ST_LAT;
        end
      end
      default: begin
        state_nxt = is_dollar ? ST_H1 : ST_HUNT;
        cnt_nxt   = 4'd0;
      end
    endcase
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      cnt_r   <= 4'd0;
    end else if (accept) begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // The comma that closes the latitude always sends the parser back to hunting.
  a_lat_end_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    push && res.field_end && (res.field_id == FID_LAT) |=> state_r == ST_HUNT)
    else $error("latitude end did not return to hunting");

  // A character is never emitted at a position beyond the field capacity.
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    push && !res.field_end |-> res.char_pos < 4'(FIELD_CHARS))
    else $error("character emitted beyond field capacity");

endmodule

FILE: hw/rtl/rmc_queue.sv
// Short queue that decouples the parser from the output register.
// Depends on rmc_pkg.
module rmc_queue
  import rmc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  rmc_res_t push_data,
  input  logic     pop,
  output logic     full,
  output logic     head_valid,
  output rmc_res_t head_data
);

  rmc_res_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue read while empty");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) || full |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with fill count");

endmodule

FILE: hw/rtl/rmc_back.sv
// Output register stage: takes results from the queue and holds them for the receiver.
// Depends on rmc_pkg; reads the head of rmc_queue.
module rmc_back
  import rmc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     head_valid,
  input  rmc_res_t head_data,
  output logic     pop,
  input  logic     out_stall,
  output logic     out_valid,
  output rmc_res_t out_data
);

  logic     out_valid_r, out_valid_nxt;
  rmc_res_t out_data_r;

  assign pop = head_valid && (!out_valid_r || !out_stall);

  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_stall) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= head_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A waiting result is picked up in the very next cycle when the register is free.
  a_fill_empty: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid && !out_valid_r |=> out_valid_r)
    else $error("output register not loaded from waiting queue");

endmodule

FILE: hw/rtl/nmea_rmc_field_extractor_top.sv
// Top level of the RMC sentence field extractor.
// Depends on rmc_pkg, rmc_front, rmc_queue and rmc_back.
//
// Usage:
//   The input channel carries one ASCII byte per transfer (in_valid, in_byte,
//   in_stall). The parser hunts for the "$GPRMC" header, skips to the first
//   comma, and then reports the UTC time field, the first character of the
//   status field and the latitude field. Each captured character becomes one
//   result transfer, and the comma closing each field becomes an end marker
//   (out_field_end high) whose out_char_pos holds the character count. Bytes
//   that produce no result are simply consumed.
//   Throughput is one byte per cycle while in_stall is low, since the parser
//   state machine decides each byte as it is taken. A result is written into
//   the two-entry queue at the edge that takes its byte, and is loaded into
//   the output register once that register is free or is being emptied.
//   When the receiver holds out_stall, results collect in the queue; in_stall
//   rises only when the queue is full, and is decoded from the queue's fill
//   count register, so it does not depend combinationally on out_stall.
//   Synchronous reset (rst_n low) returns the parser to hunting for '$',
//   clears the character count, empties the queue and drops out_valid.
module nmea_rmc_field_extractor_top
  import rmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_field_id,
  output logic [3:0] out_char_pos,
  output logic [7:0] out_field_char,
  output logic       out_field_end
);

  logic     accept;
  logic     push;
  rmc_res_t push_data;
  logic     q_full;
  logic     q_valid;
  rmc_res_t q_data;
  logic     pop;
  rmc_res_t out_data;

  // A byte is taken whenever the queue has room, whether or not it emits.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  rmc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_byte),
    .push    (push),
    .res     (push_data)
  );

  rmc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_data  (q_data)
  );

  rmc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_data  (q_data),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  assign out_field_id   = out_data.field_id;
  assign out_char_pos   = out_data.char_pos;
  assign out_field_char = out_data.field_char;
  assign out_field_end  = out_data.field_end;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for nmea_rmc_field_extractor_top.
// Depends on rmc_pkg and the block's RTL; a field scoreboard class predicts every
// captured character and end marker, while plain tasks drive bytes and stalls.
module tb_top
  import rmc_pkg::*;
;

  localparam int RANDOM_BYTES = 1850;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int LONG_HOLD    = 80;

  // Predicts the fields the parser pulls out of the byte stream and checks
  // every result transfer against the oldest prediction.
  class rmc_field_scoreboard;
    typedef enum logic [3:0] {
      HUNT, SAW_DOLLAR, SAW_G, SAW_P, SAW_R, SAW_M,
      SKIP_TO_COMMA, TIME_CHARS, STATUS_FIRST, STATUS_REST, LAT_CHARS
    } parse_phase_e;

    parse_phase_e phase;
    logic [3:0]   count;
    rmc_res_t     expected_fields[$];
    int           errors;
    int           checked;
    int           bytes_taken;
    int           headers;
    int           dropped;

    function new();
      phase = HUNT;
      count = 4'd0;
    endfunction

    function int pending();
      return expected_fields.size();
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 40)
        $display("MISMATCH @%0t: %s", $time, msg);
      else if (errors == 41)
        $display("Further mismatches are counted but not printed.");
    endfunction

    function logic [7:0] header_char(parse_phase_e p);
      case (p)
        HUNT:       return CH_DOLLAR;
        SAW_DOLLAR: return CH_G;
        SAW_G:      return CH_P;
        SAW_P:      return CH_R;
        SAW_R:      return CH_M;
        default:    return CH_C;
      endcase
    endfunction

    function void expect_field(logic [1:0] fid, logic [3:0] pos, logic [7:0] ch,
                               logic fend);
      rmc_res_t r;
      r.field_id   = fid;
      r.char_pos   = pos;
      r.field_char = ch;
      r.field_end  = fend;
      expected_fields.push_back(r);
    endfunction

    // Time and latitude: capture up to FIELD_CHARS characters, close on a comma.
    function void field_byte(logic [1:0] fid, logic [7:0] b, parse_phase_e after);
      if (b == CH_COMMA) begin
        expect_field(fid, count, 8'h00, 1'b1);
        count = 4'd0;
        phase = after;
      end else if (count < FIELD_CHARS) begin
        expect_field(fid, count, b, 1'b0);
        count++;
      end else begin
        dropped++;
      end
    endfunction

    function void take_byte(logic [7:0] b);
      bytes_taken++;
      case (phase)
        HUNT, SAW_DOLLAR, SAW_G, SAW_P, SAW_R, SAW_M: begin
          if (b == header_char(phase)) begin
            if (phase == SAW_M)
              headers++;
            phase = parse_phase_e'(phase + 1);
            count = 4'd0;
          end else begin
            phase = (b == CH_DOLLAR) ? SAW_DOLLAR : HUNT;
          end
        end
        SKIP_TO_COMMA: begin
          if (b == CH_COMMA) begin
            phase = TIME_CHARS;
            count = 4'd0;
          end
        end
        TIME_CHARS: field_byte(FID_TIME, b, STATUS_FIRST);
        STATUS_FIRST: begin
          if (b == CH_COMMA) begin
            expect_field(FID_STATUS, 4'd0, 8'h00, 1'b1);
            count = 4'd0;
            phase = LAT_CHARS;
          end else begin
            expect_field(FID_STATUS, 4'd0, b, 1'b0);
            count = 4'd1;
            phase = STATUS_REST;
          end
        end
        STATUS_REST: begin
          if (b == CH_COMMA) begin
            expect_field(FID_STATUS, count, 8'h00, 1'b1);
            count = 4'd0;
            phase = LAT_CHARS;
          end
        end
        default: field_byte(FID_LAT, b, HUNT);
      endcase
    endfunction

    function void check_result(rmc_res_t got);
      rmc_res_t want;
      if (expected_fields.size() == 0) begin
        report($sformatf("unexpected result id=%0d pos=%0d char=%02h end=%0b",
                         got.field_id, got.char_pos, got.field_char, got.field_end));
        return;
      end
      want = expected_fields.pop_front();
      checked++;
      if (got.field_id !== want.field_id)
        report($sformatf("field_id %0d, want %0d", got.field_id, want.field_id));
      if (got.char_pos !== want.char_pos)
        report($sformatf("char_pos %0d, want %0d", got.char_pos, want.char_pos));
      if (got.field_char !== want.field_char)
        report($sformatf("field_char %02h, want %02h", got.field_char, want.field_char));
      if (got.field_end !== want.field_end)
        report($sformatf("field_end %0b, want %0b", got.field_end, want.field_end));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_field_id;
  logic [3:0] out_char_pos;
  logic [7:0] out_field_char;
  logic       out_field_end;

  rmc_res_t             seen_field;
  rmc_field_scoreboard  sb;
  logic [7:0]           byte_queue[$];
  int                   cycle_count = 0;
  int                   input_held_cycles = 0;
  bit                   long_hold_done = 1'b0;

  nmea_rmc_field_extractor_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_field_id   (out_field_id),
    .out_char_pos   (out_char_pos),
    .out_field_char (out_field_char),
    .out_field_end  (out_field_end)
  );

  // The packed struct puts field_id in the top bits, matching this order.
  assign seen_field = {out_field_id, out_char_pos, out_field_char, out_field_end};

  // Clock with a period of 2: low for one unit, then high for one unit.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // A watchdog on cycles; any hang in either channel ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Results are sampled at the rising edge, where a transfer happens when
  // out_valid is high and our own out_stall is low. The same edge also counts
  // cycles in which the block pushed back on the input channel.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(seen_field);
    if (rst_n && in_valid && in_stall)
      input_held_cycles <= input_held_cycles + 1;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Any byte except a comma; a dollar shows up often to exercise the rule
  // that a dollar inside a field is just data.
  function automatic logic [7:0] random_field_char();
    logic [7:0] b;
    if ($urandom_range(0, 15) == 0)
      return CH_DOLLAR;
    do
      b = 8'($urandom_range(0, 255));
    while (b == CH_COMMA);
    return b;
  endfunction

  // Most fields are short; a few fill the capacity or run past it.
  function automatic int field_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 80) return $urandom_range(1, 10);
    if (r < 93) return $urandom_range(11, 15);
    return $urandom_range(16, 20);
  endfunction

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++)
      byte_queue.push_back(s[i]);
  endtask

  task automatic queue_field(int n);
    repeat (n) byte_queue.push_back(random_field_char());
    byte_queue.push_back(CH_COMMA);
  endtask

  // Builds one chunk of the random stream. Most chunks are complete sentences
  // with random content; the rest are broken headers, sentences that stop
  // inside the time field, and raw noise.
  task automatic queue_random_chunk();
    string hdr;
    int    kind;
    int    n;
    hdr  = "$GPRMC";
    kind = $urandom_range(0, 99);
    if (kind < 72) begin
      queue_text(hdr);
      // Characters between the header and its first comma are skipped.
      repeat ($urandom_range(0, 3)) byte_queue.push_back(random_field_char());
      byte_queue.push_back(CH_COMMA);
      queue_field(field_len());
      queue_field($urandom_range(0, 3));
      queue_field(field_len());
    end else if (kind < 84) begin
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++)
        byte_queue.push_back(hdr[i]);
      byte_queue.push_back($urandom_range(0, 1) ? CH_DOLLAR : 8'($urandom_range(0, 255)));
    end else if (kind < 92) begin
      // A cut-off sentence: whatever follows is taken as time characters.
      queue_text("$GPRMC,");
      repeat ($urandom_range(0, 6)) byte_queue.push_back(random_field_char());
    end else begin
      repeat ($urandom_range(1, 12)) byte_queue.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // One input transfer. Entered at a falling edge; in_valid stays high while
  // the block stalls, and the byte is handed to the scoreboard only at the
  // edge where it is actually taken. Returns at the next falling edge.
  task automatic send_byte(logic [7:0] b);
    in_valid <= 1'b1;
    in_byte  <= b;
    do
      @(posedge clk);
    while (in_stall !== 1'b0);
    sb.take_byte(b);
    @(negedge clk);
  endtask

  // Sends everything queued. A quiet chunk goes back to back; otherwise the
  // sender idles for a random number of cycles after each transfer.
  task automatic send_queued(bit quiet);
    int n;
    while (byte_queue.size() != 0) begin
      send_byte(byte_queue.pop_front());
      n = quiet ? 0 : gap_len();
      if (n > 0) begin
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  endtask

  // Receiver side: runs of acceptance broken by stalls of random length,
  // with occasional long stretches of no stall at all. Once enough results
  // have been checked, the receiver holds out_stall in one unbroken stall while
  // the sender keeps offering bytes, which fills the block's queue and must push
  // back on the input channel.
  initial begin : receiver_stall
    int run;
    int hold;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (!long_hold_done && sb.checked >= 300) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_done = 1'b1;
      end
      out_stall <= 1'b0;
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
      repeat (run) @(negedge clk);
      hold = gap_len();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
    end
  end

  // Sender side and run control.
  initial begin : sender
    int  start_bytes;
    bit  drained_once;
    sb = new();
    drained_once = 1'b0;

    // Reset is held low and released at a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed stream. The first sentence covers header mismatches (a dollar
    // that restarts the match and a letter that drops back to hunting),
    // junk before the first comma, the byte extremes and a dollar inside the
    // time field, and a status field with extra characters. The second has
    // empty time and status fields, and a latitude that runs past capacity.
    queue_text("$G$GPRMX$GPRMC");
    byte_queue.push_back(8'hFF);
    queue_text("9,");
    byte_queue.push_back(8'h00);
    byte_queue.push_back(8'hFF);
    queue_text("$,AV,4,");
    queue_text("$GPRMC,,,0123456789ABCDEFG,");
    send_queued(1'b0);

    // Random stream.
    start_bytes = sb.bytes_taken;
    while (sb.bytes_taken - start_bytes < RANDOM_BYTES) begin
      queue_random_chunk();
      send_queued($urandom_range(0, 4) == 0);
      // Once, halfway through, the sender waits for every result to drain.
      if (!drained_once && sb.bytes_taken - start_bytes >= RANDOM_BYTES / 2) begin
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        @(negedge clk);
        drained_once = 1'b1;
      end
    end

    // Drain whatever is still in flight, then allow a few quiet cycles so a
    // stray extra result would still be caught.
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Sent %0d bytes with %0d full headers; checked %0d results, %0d bytes over capacity.",
             sb.bytes_taken, sb.headers, sb.checked, sb.dropped);
    $display("Input was held back on %0d cycles; mismatches: %0d.",
             input_held_cycles, sb.errors);
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
